// ----- rtl/wmrc_pkg.sv -----
// Shared constants, codes and saturation helpers for the windowed MLP risk classifier.
package wmrc_pkg;

    localparam int WINDOW_DEPTH = 10;
    localparam int HIDDEN_UNITS = 12;
    localparam int CLASS_COUNT  = 3;
    localparam int VOTE_DEPTH   = 3;

    localparam int FEATS      = 2 * WINDOW_DEPTH;
    localparam int HIGH_CLASS = 2;
    localparam int VOTE_NEED  = 2;

    // Flat coefficient address map.
    localparam int A_MEAN = 0;
    localparam int A_INV  = A_MEAN + FEATS;
    localparam int A_W1   = A_INV + FEATS;
    localparam int A_B1   = A_W1 + FEATS * HIDDEN_UNITS;
    localparam int A_W2   = A_B1 + HIDDEN_UNITS;
    localparam int A_B2   = A_W2 + HIDDEN_UNITS * CLASS_COUNT;
    localparam int A_END  = A_B2 + CLASS_COUNT;

    localparam int COEF_AW = $clog2(A_END);

    // Fixed field widths.
    localparam int TEMP_W   = 16;
    localparam int HUMID_W  = 15;
    localparam int CADDR_W  = 9;
    localparam int CVAL_W   = 16;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 4;
    localparam int RISK_W   = 2;
    localparam int LOGIT_W  = 32;
    localparam int SCALE_W  = 24;
    localparam int CFG_IDX_W = 2;

    // Internal widths.
    localparam int FI_W  = (FEATS > 1) ? $clog2(FEATS) : 1;
    localparam int U_W   = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;
    localparam int CLS_W = $clog2(CLASS_COUNT);
    localparam int WH_W  = $clog2(WINDOW_DEPTH);
    localparam int WC_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int VH_W  = $clog2(VOTE_DEPTH);
    localparam int VF_W  = $clog2(VOTE_DEPTH + 1);
    localparam int MUL_W  = 34;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = 40;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_HW_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HB_SCALE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OW_SCALE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OB_SCALE = 2'd3;
    localparam logic [SCALE_W-1:0]   SCALE_ONE    = 24'd65536;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_WARMUP     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CLASSIFIED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ERROR      = 2'd2;

    function automatic logic signed [31:0] sat32_prod(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        hi = PROD_W'(32'sh7FFFFFFF);
        lo = PROD_W'(32'sh80000000);
        if (v > hi) return 32'sh7FFFFFFF;
        else if (v < lo) return 32'sh80000000;
        else return v[31:0];
    endfunction

    function automatic logic signed [31:0] sat32_acc(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(32'sh7FFFFFFF);
        lo = ACC_W'(32'sh80000000);
        if (v > hi) return 32'sh7FFFFFFF;
        else if (v < lo) return 32'sh80000000;
        else return v[31:0];
    endfunction

    function automatic logic signed [15:0] sat16_prod(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        hi = PROD_W'(16'sh7FFF);
        lo = PROD_W'(16'sh8000);
        if (v > hi) return 16'sh7FFF;
        else if (v < lo) return 16'sh8000;
        else return v[15:0];
    endfunction

endpackage

// ----- rtl/wmrc_in_if.sv -----
// Input channel: a sensor sample or a coefficient write per beat.
interface wmrc_in_if;
    logic                                valid;
    logic                                ready;
    logic                                kind;
    logic                                sample_valid;
    logic signed [wmrc_pkg::TEMP_W-1:0]  temperature;
    logic [wmrc_pkg::HUMID_W-1:0]        humidity;
    logic [wmrc_pkg::CADDR_W-1:0]        coef_address;
    logic signed [wmrc_pkg::CVAL_W-1:0]  coef_value;

    modport source (output valid, kind, sample_valid, temperature, humidity, coef_address,
                    coef_value, input ready);
    modport sink (input valid, kind, sample_valid, temperature, humidity, coef_address,
                  coef_value, output ready);
endinterface

// ----- rtl/wmrc_out_if.sv -----
// Output channel: one result (classified, warmup or error) per beat.
interface wmrc_out_if;
    logic                                valid;
    logic                                ready;
    logic [wmrc_pkg::STATUS_W-1:0]       status;
    logic [wmrc_pkg::FILL_W-1:0]         window_fill;
    logic [wmrc_pkg::RISK_W-1:0]         risk_class;
    logic                                high_vote;
    logic signed [wmrc_pkg::LOGIT_W-1:0] top_logit;

    modport source (output valid, status, window_fill, risk_class, high_vote, top_logit,
                    input ready);
    modport sink (input valid, status, window_fill, risk_class, high_vote, top_logit,
                  output ready);
endinterface

// ----- rtl/windowed_mlp_risk_classifier.sv -----
// Top level: sample window, normalization and a two-layer MLP on one shared multiplier.
//
// Each input beat is either a coefficient write (taken while idle, no result) or a
// sensor sample. A failed read or a sample during warmup has its result staged and then
// loaded into the output register once that register is free. Once the window is full,
// a sample runs a classification over its 2*WINDOW_DEPTH features, its length set by the
// single multiplier and the single read port of the coefficient memory, which every step
// of both layers goes through in turn. The input is not ready during that time. One
// finished result waits in the output register, so a new beat is taken while it is still
// held. Coefficients must be loaded before the first classification; the four scale
// registers reset to 1.0.
module windowed_mlp_risk_classifier (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    wmrc_in_if.sink                              i_in,
    wmrc_out_if.source                           o_out,
    input  logic                                 i_cfg_we,
    input  logic [wmrc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [wmrc_pkg::SCALE_W-1:0]         i_cfg_data
);
    import wmrc_pkg::*;

    typedef enum logic [20:0] {
        S_IDLE = 21'h000001,
        S_N0   = 21'h000002,
        S_N1   = 21'h000004,
        S_N2   = 21'h000008,
        S_N3   = 21'h000010,
        S_HB0  = 21'h000020,
        S_HB1  = 21'h000040,
        S_HB2  = 21'h000080,
        S_H1   = 21'h000100,
        S_H2   = 21'h000200,
        S_H3   = 21'h000400,
        S_H4   = 21'h000800,
        S_OB0  = 21'h001000,
        S_OB1  = 21'h002000,
        S_OB2  = 21'h004000,
        S_O1   = 21'h008000,
        S_O2   = 21'h010000,
        S_O3   = 21'h020000,
        S_O4   = 21'h040000,
        S_VOTE = 21'h080000,
        S_EMIT = 21'h100000
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [SCALE_W-1:0] r_hw_scale, r_hb_scale, r_ow_scale, r_ob_scale;

    // Window and vote state.
    logic signed [TEMP_W-1:0] r_temp [WINDOW_DEPTH];
    logic [HUMID_W-1:0]       r_humid [WINDOW_DEPTH];
    logic [WH_W-1:0]          r_head;
    logic [WC_W-1:0]          r_fill;
    logic [VOTE_DEPTH-1:0]    r_vote_bits;
    logic [VH_W-1:0]          r_vhead;
    logic [VF_W-1:0]          r_vfill;

    // Coefficient memory.
    logic [CVAL_W-1:0] r_coef_mem [A_END];
    logic [CVAL_W-1:0] r_rdata;
    logic [COEF_AW-1:0] rd_addr;

    // Datapath working registers.
    logic signed [15:0]      r_feat [FEATS];
    logic signed [31:0]      r_hid [HIDDEN_UNITS];
    logic [FI_W-1:0]         r_i;
    logic [U_W-1:0]          r_u;
    logic [CLS_W-1:0]        r_c;
    logic [WH_W-1:0]         r_widx;
    logic signed [CVAL_W-1:0] r_mean;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] r_best;
    logic [CLS_W-1:0]        r_cls;

    // Pending result and output register.
    logic [STATUS_W-1:0]     r_res_status;
    logic [FILL_W-1:0]       r_res_fill;
    logic [RISK_W-1:0]       r_res_risk;
    logic                    r_res_vote;
    logic signed [LOGIT_W-1:0] r_res_logit;
    logic                    r_out_valid;
    logic [STATUS_W-1:0]     r_out_status;
    logic [FILL_W-1:0]       r_out_fill;
    logic [RISK_W-1:0]       r_out_risk;
    logic                    r_out_vote;
    logic signed [LOGIT_W-1:0] r_out_logit;

    logic                     in_acc;
    logic                     coef_we;
    logic                     out_load;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [17:0]       norm_x;
    logic [WC_W-1:0]          fill_next;
    logic [VOTE_DEPTH-1:0]    vote_next;
    logic [VF_W-1:0]          vfill_next;
    logic                     voted;

    assign in_acc     = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign coef_we    = in_acc && i_in.kind && (COEF_AW'(i_in.coef_address) < COEF_AW'(A_END));
    assign out_load   = (r_state == S_EMIT) && (!r_out_valid || o_out.ready);
    assign fill_next  = (r_fill == WC_W'(WINDOW_DEPTH)) ? r_fill : r_fill + WC_W'(1);

    wmrc_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // Raw feature: even slots are temperature, odd slots humidity.
    always_comb begin
        if (r_i[0]) begin
            norm_x = 18'(signed'({1'b0, r_humid[r_widx]})) - 18'(r_mean);
        end else begin
            norm_x = 18'(r_temp[r_widx]) - 18'(r_mean);
        end
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_N2: begin
                mul_a = MUL_W'(norm_x);
                mul_b = MUL_W'(signed'(r_rdata));
            end
            S_HB1: begin
                mul_a = MUL_W'(signed'(r_rdata[7:0]));
                mul_b = signed'(MUL_W'(r_hb_scale));
            end
            S_H1: begin
                mul_a = MUL_W'(signed'(r_rdata[7:0]));
                mul_b = signed'(MUL_W'(r_hw_scale));
            end
            S_H2: begin
                mul_a = MUL_W'(r_feat[r_i]);
                mul_b = MUL_W'(signed'(prod[32:0]));
            end
            S_OB1: begin
                mul_a = MUL_W'(signed'(r_rdata[7:0]));
                mul_b = signed'(MUL_W'(r_ob_scale));
            end
            S_O1: begin
                mul_a = MUL_W'(signed'(r_rdata[7:0]));
                mul_b = signed'(MUL_W'(r_ow_scale));
            end
            S_O2: begin
                mul_a = MUL_W'(r_hid[r_u]);
                mul_b = MUL_W'(signed'(prod[32:0]));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Read address for the next cycle's coefficient; the weight states fetch one ahead.
    always_comb begin
        case (r_state)
            S_N0:  rd_addr = COEF_AW'(A_MEAN) + COEF_AW'(r_i);
            S_N1:  rd_addr = COEF_AW'(A_INV) + COEF_AW'(r_i);
            S_HB0: rd_addr = COEF_AW'(A_B1) + COEF_AW'(r_u);
            S_HB2: rd_addr = COEF_AW'(A_W1) + COEF_AW'(r_u);
            S_H3:  rd_addr = COEF_AW'(A_W1) + (COEF_AW'(r_i) + COEF_AW'(1))
                             * COEF_AW'(HIDDEN_UNITS) + COEF_AW'(r_u);
            S_OB0: rd_addr = COEF_AW'(A_B2) + COEF_AW'(r_c);
            S_OB2: rd_addr = COEF_AW'(A_W2) + COEF_AW'(r_c);
            S_O3:  rd_addr = COEF_AW'(A_W2) + (COEF_AW'(r_u) + COEF_AW'(1))
                             * COEF_AW'(CLASS_COUNT) + COEF_AW'(r_c);
            default: rd_addr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (coef_we) begin
            r_coef_mem[COEF_AW'(i_in.coef_address)] <= i_in.coef_value;
        end
        r_rdata <= r_coef_mem[rd_addr];
    end

    // Vote over the last results, including the one being finished now.
    always_comb begin
        vote_next = r_vote_bits;
        vote_next[r_vhead] = (r_cls == CLS_W'(HIGH_CLASS));
        vfill_next = (r_vfill == VF_W'(VOTE_DEPTH)) ? r_vfill : r_vfill + VF_W'(1);
        voted = (vfill_next == VF_W'(VOTE_DEPTH)) && ($countones(vote_next) >= VOTE_NEED);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hw_scale  <= SCALE_ONE;
            r_hb_scale  <= SCALE_ONE;
            r_ow_scale  <= SCALE_ONE;
            r_ob_scale  <= SCALE_ONE;
            r_head      <= '0;
            r_fill      <= '0;
            r_vote_bits <= '0;
            r_vhead     <= '0;
            r_vfill     <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < WINDOW_DEPTH; k++) begin
                r_temp[k]  <= '0;
                r_humid[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_HW_SCALE: r_hw_scale <= i_cfg_data;
                    CFG_HB_SCALE: r_hb_scale <= i_cfg_data;
                    CFG_OW_SCALE: r_ow_scale <= i_cfg_data;
                    CFG_OB_SCALE: r_ob_scale <= i_cfg_data;
                    default: ;
                endcase
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc && !i_in.kind) begin
                        r_res_risk  <= '0;
                        r_res_vote  <= 1'b0;
                        r_res_logit <= '0;
                        if (!i_in.sample_valid) begin
                            r_res_status <= ST_ERROR;
                            r_res_fill   <= FILL_W'(r_fill);
                            r_state      <= S_EMIT;
                        end else begin
                            r_temp[r_head]  <= i_in.temperature;
                            r_humid[r_head] <= i_in.humidity;
                            r_fill          <= fill_next;
                            r_res_fill      <= FILL_W'(fill_next);
                            if (r_head == WH_W'(WINDOW_DEPTH - 1)) begin
                                r_head <= '0;
                                r_widx <= '0;
                            end else begin
                                r_head <= r_head + WH_W'(1);
                                r_widx <= r_head + WH_W'(1);
                            end
                            r_i <= '0;
                            if (fill_next == WC_W'(WINDOW_DEPTH)) begin
                                r_state <= S_N0;
                            end else begin
                                r_res_status <= ST_WARMUP;
                                r_state      <= S_EMIT;
                            end
                        end
                    end
                end
                S_N0: r_state <= S_N1;
                S_N1: begin
                    r_mean  <= signed'(r_rdata);
                    r_state <= S_N2;
                end
                S_N2: r_state <= S_N3;
                S_N3: begin
                    r_feat[r_i] <= sat16_prod(prod >>> 8);
                    if (r_i[0]) begin
                        r_widx <= (r_widx == WH_W'(WINDOW_DEPTH - 1)) ? '0 : r_widx + WH_W'(1);
                    end
                    if (r_i == FI_W'(FEATS - 1)) begin
                        r_i     <= '0;
                        r_u     <= '0;
                        r_state <= S_HB0;
                    end else begin
                        r_i     <= r_i + FI_W'(1);
                        r_state <= S_N0;
                    end
                end
                S_HB0: r_state <= S_HB1;
                S_HB1: r_state <= S_HB2;
                S_HB2: begin
                    r_acc   <= ACC_W'(prod);
                    r_i     <= '0;
                    r_state <= S_H1;
                end
                S_H1: r_state <= S_H2;
                S_H2: r_state <= S_H3;
                S_H3: begin
                    r_acc <= r_acc + ACC_W'(sat32_prod(prod >>> 8));
                    if (r_i == FI_W'(FEATS - 1)) begin
                        r_state <= S_H4;
                    end else begin
                        r_i     <= r_i + FI_W'(1);
                        r_state <= S_H1;
                    end
                end
                S_H4: begin
                    r_hid[r_u] <= (r_acc < 0) ? 32'sd0 : sat32_acc(r_acc);
                    if (r_u == U_W'(HIDDEN_UNITS - 1)) begin
                        r_c     <= '0;
                        r_state <= S_OB0;
                    end else begin
                        r_u     <= r_u + U_W'(1);
                        r_state <= S_HB0;
                    end
                end
                S_OB0: r_state <= S_OB1;
                S_OB1: r_state <= S_OB2;
                S_OB2: begin
                    r_acc   <= ACC_W'(prod);
                    r_u     <= '0;
                    r_state <= S_O1;
                end
                S_O1: r_state <= S_O2;
                S_O2: r_state <= S_O3;
                S_O3: begin
                    r_acc <= r_acc + ACC_W'(sat32_prod(prod >>> 16));
                    if (r_u == U_W'(HIDDEN_UNITS - 1)) begin
                        r_state <= S_O4;
                    end else begin
                        r_u     <= r_u + U_W'(1);
                        r_state <= S_O1;
                    end
                end
                S_O4: begin
                    // The first class wins a tie, so only a strictly larger sum replaces it.
                    if (r_c == '0 || r_acc > r_best) begin
                        r_best <= r_acc;
                        r_cls  <= r_c;
                    end
                    if (r_c == CLS_W'(CLASS_COUNT - 1)) begin
                        r_state <= S_VOTE;
                    end else begin
                        r_c     <= r_c + CLS_W'(1);
                        r_state <= S_OB0;
                    end
                end
                S_VOTE: begin
                    r_vote_bits  <= vote_next;
                    r_vhead      <= (r_vhead == VH_W'(VOTE_DEPTH - 1)) ? '0 : r_vhead + VH_W'(1);
                    r_vfill      <= vfill_next;
                    r_res_status <= ST_CLASSIFIED;
                    r_res_risk   <= RISK_W'(r_cls);
                    r_res_vote   <= voted;
                    r_res_logit  <= sat32_acc(r_best);
                    r_state      <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status <= r_res_status;
            r_out_fill   <= r_res_fill;
            r_out_risk   <= r_res_risk;
            r_out_vote   <= r_res_vote;
            r_out_logit  <= r_res_logit;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_out_status;
    assign o_out.window_fill = r_out_fill;
    assign o_out.risk_class  = r_out_risk;
    assign o_out.high_vote   = r_out_vote;
    assign o_out.top_logit   = r_out_logit;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= WC_W'(WINDOW_DEPTH))
        else $error("window fill count exceeds the window depth");

    a_class_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status == ST_CLASSIFIED) |->
            (o_out.window_fill == FILL_W'(WINDOW_DEPTH)))
        else $error("classified result without a full window");

    a_start_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_N0 && $past(r_state) == S_IDLE) |-> (r_fill == WC_W'(WINDOW_DEPTH)))
        else $error("classification started before the window filled");

    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.risk_class < RISK_W'(CLASS_COUNT)))
        else $error("risk class out of range");
endmodule

// ----- rtl/wmrc_mul.sv -----
// Shared signed multiplier with a registered product.
module wmrc_mul (
    input  logic                                 i_clk,
    input  logic signed [wmrc_pkg::MUL_W-1:0]    i_a,
    input  logic signed [wmrc_pkg::MUL_W-1:0]    i_b,
    output logic signed [wmrc_pkg::PROD_W-1:0]   o_prod
);
    import wmrc_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;
endmodule
